// File: rtl/bfpa_pkg.sv
// ----------------------------------------------------------------------------
// Best-fit page allocator package
// Shared widths, status and kind codes, controller states, and the command
// and status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package bfpa_pkg;

  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned BYTES_W     = 23;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned PAGE_BYTES  = 4096;
  localparam int unsigned PAGE_SHIFT  = $clog2(PAGE_BYTES);
  // Width of the rounded-up page count of the largest request.
  localparam int unsigned REQ_PAGES_W = BYTES_W - PAGE_SHIFT + 1;

  localparam logic [ADDR_W-1:0] HEAP_BASE_RST = 32'hF600_0000;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_ZERO     = 3'd1,
    ST_NOFIT    = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_SLOT,
    S_SCAN,
    S_EVAL,
    S_MARK,
    S_WALK,
    S_UNMARK,
    S_RESP
  } ctrl_state_e;

  typedef struct packed {
    logic    load;        // capture the accepted request
    logic    sweep;       // clear one page of the map after reset
    logic    slot_clear;  // restart the record slot counter
    logic    slot_step;   // test one slot for a free entry
    logic    scan_start;  // restart the page scan and best-run tracking
    logic    scan_step;   // one page of the scan
    logic    rec_alloc;   // write the new record
    logic    mark;        // mark one page of the granted run used
    logic    walk_step;   // compare one record against the free address
    logic    unmark;      // release one page of the matched record
    logic    rsp_load;    // load the output register
    logic    rsp_grant;   // output carries the granted address
    status_e rsp_status;
  } bfpa_cmd_t;

  typedef struct packed {
    logic kind_free;
    logic zero;
    logic sweep_last;
    logic slot_free;
    logic slot_end;
    logic scan_done;
    logic have_best;
    logic mark_last;
    logic walk_hit;
    logic walk_end;
    logic unmark_last;
    logic rsp_busy;
  } bfpa_sts_t;

endpackage

// File: rtl/bfpa_req_if.sv
// ----------------------------------------------------------------------------
// Best-fit page allocator request channel
// Valid/ready channel carrying one allocate or free request per beat.
// ----------------------------------------------------------------------------
interface bfpa_req_if import bfpa_pkg::*; ();

  logic               valid;
  logic               ready;
  logic               kind;
  logic [BYTES_W-1:0] request_bytes;
  logic [ADDR_W-1:0]  free_address;

  modport source (output valid, output kind, output request_bytes,
                  output free_address, input ready);
  modport sink   (input valid, input kind, input request_bytes,
                  input free_address, output ready);

endinterface

// File: rtl/bfpa_rsp_if.sv
// ----------------------------------------------------------------------------
// Best-fit page allocator response channel
// Valid/ready channel carrying one result per beat.
// ----------------------------------------------------------------------------
interface bfpa_rsp_if import bfpa_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   granted_address;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output granted_address, output status, input ready);
  modport sink   (input valid, input granted_address, input status, output ready);

endinterface

// File: rtl/bfpa_cfg_if.sv
// ----------------------------------------------------------------------------
// Best-fit page allocator configuration channel
// Valid/ready write channel for the heap base register.
// ----------------------------------------------------------------------------
interface bfpa_cfg_if import bfpa_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] heap_base;

  modport source (output valid, output heap_base, input ready);
  modport sink   (input valid, input heap_base, output ready);

endinterface

// File: rtl/best_fit_page_allocator.sv
// ----------------------------------------------------------------------------
// Best-fit page allocator
// An allocate searches the record slots for the first free one, scans the
// occupancy map one page per cycle and marks the pages granted; a free walks
// the record slots up to the matching one and releases its pages.
// One request is in flight at a time; the next is taken once the result is
// in the output register. After reset the map is swept clear, during which
// no request is accepted.
// ----------------------------------------------------------------------------
module best_fit_page_allocator import bfpa_pkg::*; #(
  parameter int unsigned HEAP_PAGES   = 1024,
  parameter int unsigned RECORD_SLOTS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bfpa_req_if.sink   req_i,
  bfpa_rsp_if.source rsp_o,
  bfpa_cfg_if.sink   cfg_i
);

  // The controller walks through the request in distinct phases: a slot
  // search over the record valid bits, a scan of every page plus an
  // end-of-heap marker that closes the last run, then a page-by-page marking
  // or release pass. The datapath holds the occupancy map and record table as
  // memories with one write port and a registered read port, so the scan and
  // the record walk judge each entry in the cycle after its read is issued.

  bfpa_cmd_t cmd;
  bfpa_sts_t sts;

  // The heap base register is always writable. Configuration beats must only be
  // sent while the block is idle; the block itself does not enforce this.
  assign cfg_i.ready = 1'b1;

  bfpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The output register parts the response side from the controller, so a
  // finished result may wait while the next request beat is taken.
  bfpa_datapath #(
    .HEAP_PAGES   (HEAP_PAGES),
    .RECORD_SLOTS (RECORD_SLOTS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .req_kind_i   (req_i.kind),
    .req_bytes_i  (req_i.request_bytes),
    .req_addr_i   (req_i.free_address),
    .cfg_we_i     (cfg_i.valid),
    .cfg_data_i   (cfg_i.heap_base),
    .rsp_ready_i  (rsp_o.ready),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_addr_o   (rsp_o.granted_address),
    .rsp_status_o (rsp_o.status)
  );

endmodule

// File: rtl/bfpa_datapath.sv
// ----------------------------------------------------------------------------
// Best-fit page allocator datapath
// Occupancy map, record table, scan and walk pipelines, and output register.
// ----------------------------------------------------------------------------
module bfpa_datapath import bfpa_pkg::*; #(
  parameter int unsigned HEAP_PAGES   = 1024,
  parameter int unsigned RECORD_SLOTS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bfpa_cmd_t          cmd_i,
  output bfpa_sts_t          sts_o,
  input  logic               req_kind_i,
  input  logic [BYTES_W-1:0] req_bytes_i,
  input  logic [ADDR_W-1:0]  req_addr_i,
  input  logic               cfg_we_i,
  input  logic [ADDR_W-1:0]  cfg_data_i,
  input  logic               rsp_ready_i,
  output logic               rsp_valid_o,
  output logic [ADDR_W-1:0]  rsp_addr_o,
  output logic [STATUS_W-1:0] rsp_status_o
);

  localparam int unsigned PW  = $clog2(HEAP_PAGES);
  localparam int unsigned CW  = $clog2(HEAP_PAGES + 1);
  localparam int unsigned SW  = (RECORD_SLOTS > 1) ? $clog2(RECORD_SLOTS) : 1;
  localparam int unsigned SCW = $clog2(RECORD_SLOTS + 1);
  localparam int unsigned MW  = (CW > REQ_PAGES_W) ? CW : REQ_PAGES_W;
  localparam int unsigned RW  = PW + CW;

  logic [ADDR_W-1:0]      heap_base_q;
  logic                   kind_q;
  logic                   zero_q;
  logic [REQ_PAGES_W-1:0] req_pages_q;
  logic [ADDR_W-1:0]      free_addr_q;

  logic [SCW-1:0]          slot_cnt_q;
  logic [SW-1:0]           slot_q;
  logic [RECORD_SLOTS-1:0] rec_valid_q;
  logic [CW-1:0]           page_cnt_q;

  logic          pg_mem [HEAP_PAGES];
  logic          pg_rd_q;
  logic          pipe_vld_q;
  logic [CW-1:0] pipe_idx_q;
  logic          pg_we;
  logic [PW-1:0] pg_waddr;
  logic          pg_wdata;

  logic [CW-1:0] run_q;
  logic [PW-1:0] run_start_q;
  logic [CW-1:0] best_len_q;
  logic [PW-1:0] best_start_q;
  logic          have_best_q;

  logic [RW-1:0]  rec_mem [RECORD_SLOTS];
  logic [RW-1:0]  rec_rd_q;
  logic           rec_pipe_q;
  logic [SCW-1:0] rec_idx_q;
  logic           rec_vld_rd_q;
  logic [PW-1:0]  free_start_q;
  logic [CW-1:0]  free_cnt_q;

  logic                rsp_valid_q;
  logic [ADDR_W-1:0]   rsp_addr_q;
  logic [STATUS_W-1:0] rsp_status_q;

  logic [SW-1:0]  slot_idx;
  logic           slot_end;
  logic           free_here;
  logic           run_fits;
  logic [PW-1:0]  rec_start;
  logic [CW-1:0]  rec_count;
  logic           walk_hit;
  logic [CW-1:0]  mark_off;
  logic [CW:0]    unmark_page;
  logic [REQ_PAGES_W-1:0] req_pages;

  assign req_pages = REQ_PAGES_W'(req_bytes_i[BYTES_W-1:PAGE_SHIFT])
                   + REQ_PAGES_W'(|req_bytes_i[PAGE_SHIFT-1:0]);

  assign slot_idx  = slot_cnt_q[SW-1:0];
  assign slot_end  = (slot_cnt_q == SCW'(RECORD_SLOTS));

  // A run closes at a used page or at the end-of-heap marker.
  assign free_here = (pipe_idx_q != CW'(HEAP_PAGES)) && !pg_rd_q;
  assign run_fits  = (MW'(run_q) >= MW'(req_pages_q))
                  && (!have_best_q || (run_q < best_len_q));

  assign rec_start = rec_rd_q[RW-1:CW];
  assign rec_count = rec_rd_q[CW-1:0];
  assign walk_hit  = rec_pipe_q && rec_vld_rd_q
                  && ((heap_base_q + ADDR_W'({rec_start, {PAGE_SHIFT{1'b0}}}))
                      == free_addr_q);

  assign mark_off    = CW'(best_start_q) + page_cnt_q;
  assign unmark_page = (CW + 1)'(free_start_q) + (CW + 1)'(page_cnt_q);

  always_comb begin
    pg_we    = 1'b0;
    pg_waddr = page_cnt_q[PW-1:0];
    pg_wdata = 1'b0;
    if (cmd_i.sweep) begin
      pg_we = 1'b1;
    end else if (cmd_i.mark) begin
      pg_we    = 1'b1;
      pg_waddr = mark_off[PW-1:0];
      pg_wdata = 1'b1;
    end else if (cmd_i.unmark) begin
      pg_we    = (unmark_page < (CW + 1)'(HEAP_PAGES));
      pg_waddr = unmark_page[PW-1:0];
    end
  end

  // Occupancy map: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (pg_we) begin
      pg_mem[pg_waddr] <= pg_wdata;
    end
    pg_rd_q <= pg_mem[page_cnt_q[PW-1:0]];
  end

  // Record table: start page and page count per slot.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rec_alloc) begin
      rec_mem[slot_q] <= {best_start_q, CW'(req_pages_q)};
    end
    rec_rd_q <= rec_mem[slot_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q <= HEAP_BASE_RST;
    end else if (cfg_we_i) begin
      heap_base_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q      <= req_kind_i;
      zero_q      <= (req_bytes_i == '0);
      req_pages_q <= req_pages;
      free_addr_q <= req_addr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_cnt_q <= '0;
    end else if (cmd_i.scan_start || cmd_i.rec_alloc || (cmd_i.walk_step && walk_hit)) begin
      page_cnt_q <= '0;
    end else if (cmd_i.sweep || cmd_i.mark || cmd_i.unmark) begin
      page_cnt_q <= page_cnt_q + CW'(1);
    end else if (cmd_i.scan_step && (page_cnt_q != CW'(HEAP_PAGES))) begin
      page_cnt_q <= page_cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_cnt_q   <= '0;
      slot_q       <= '0;
      rec_valid_q  <= '0;
      rec_pipe_q   <= 1'b0;
      rec_idx_q    <= '0;
      rec_vld_rd_q <= 1'b0;
      free_start_q <= '0;
      free_cnt_q   <= '0;
    end else begin
      if (cmd_i.slot_clear) begin
        slot_cnt_q <= '0;
      end else if ((cmd_i.slot_step || cmd_i.walk_step) && !slot_end) begin
        slot_cnt_q <= slot_cnt_q + SCW'(1);
      end
      if (cmd_i.slot_step && !slot_end && !rec_valid_q[slot_idx]) begin
        slot_q <= slot_idx;
      end
      if (cmd_i.rec_alloc) begin
        rec_valid_q[slot_q] <= 1'b1;
      end
      rec_pipe_q   <= cmd_i.walk_step;
      rec_idx_q    <= slot_cnt_q;
      rec_vld_rd_q <= !slot_end && rec_valid_q[slot_idx];
      if (cmd_i.walk_step && walk_hit) begin
        free_start_q                      <= rec_start;
        free_cnt_q                        <= rec_count;
        rec_valid_q[rec_idx_q[SW-1:0]]    <= 1'b0;
      end
    end
  end

  // Scan pipeline: the read issued for a page is judged in the next cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_vld_q   <= 1'b0;
      pipe_idx_q   <= '0;
      run_q        <= '0;
      run_start_q  <= '0;
      best_len_q   <= '0;
      best_start_q <= '0;
      have_best_q  <= 1'b0;
    end else if (cmd_i.scan_start) begin
      pipe_vld_q  <= 1'b0;
      run_q       <= '0;
      have_best_q <= 1'b0;
    end else begin
      pipe_vld_q <= cmd_i.scan_step;
      pipe_idx_q <= page_cnt_q;
      if (cmd_i.scan_step && pipe_vld_q) begin
        if (free_here) begin
          if (run_q == '0) begin
            run_start_q <= pipe_idx_q[PW-1:0];
          end
          run_q <= run_q + CW'(1);
        end else begin
          if (run_fits) begin
            have_best_q  <= 1'b1;
            best_len_q   <= run_q;
            best_start_q <= run_start_q;
          end
          run_q <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_i.rsp_load) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rsp_load) begin
      rsp_status_q <= cmd_i.rsp_status;
      rsp_addr_q   <= cmd_i.rsp_grant
                    ? heap_base_q + ADDR_W'({best_start_q, {PAGE_SHIFT{1'b0}}})
                    : '0;
    end
  end

  assign rsp_valid_o  = rsp_valid_q;
  assign rsp_addr_o   = rsp_addr_q;
  assign rsp_status_o = rsp_status_q;

  always_comb begin
    sts_o             = '0;
    sts_o.kind_free   = (kind_q == KIND_FREE);
    sts_o.zero        = zero_q;
    sts_o.sweep_last  = (page_cnt_q == CW'(HEAP_PAGES - 1));
    sts_o.slot_free   = !slot_end && !rec_valid_q[slot_idx];
    sts_o.slot_end    = slot_end;
    sts_o.scan_done   = pipe_vld_q && (pipe_idx_q == CW'(HEAP_PAGES));
    sts_o.have_best   = have_best_q;
    sts_o.mark_last   = (MW'(page_cnt_q) == (MW'(req_pages_q) - MW'(1)));
    sts_o.walk_hit    = walk_hit;
    sts_o.walk_end    = rec_pipe_q && (rec_idx_q == SCW'(RECORD_SLOTS));
    sts_o.unmark_last = (page_cnt_q == (free_cnt_q - CW'(1)));
    sts_o.rsp_busy    = rsp_valid_q && !rsp_ready_i;
  end

endmodule

// File: rtl/bfpa_ctrl.sv
// ----------------------------------------------------------------------------
// Best-fit page allocator controller
// Sequences the reset sweep, slot search, page scan, marking and freeing.
// ----------------------------------------------------------------------------
module bfpa_ctrl import bfpa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_ready_o,
  input  bfpa_sts_t sts_i,
  output bfpa_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  status_e     code_q, code_d;
  logic        grant_q, grant_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      code_q  <= ST_OK;
      grant_q <= 1'b0;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
      grant_q <= grant_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    code_d      = code_q;
    grant_d     = grant_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.slot_clear = 1'b1;
        grant_d          = 1'b0;
        if (sts_i.kind_free) begin
          state_d = S_WALK;
        end else if (sts_i.zero) begin
          code_d  = ST_ZERO;
          state_d = S_RESP;
        end else begin
          state_d = S_SLOT;
        end
      end
      S_SLOT: begin
        cmd_o.slot_step = 1'b1;
        if (sts_i.slot_free) begin
          cmd_o.scan_start = 1'b1;
          state_d          = S_SCAN;
        end else if (sts_i.slot_end) begin
          code_d  = ST_FULL;
          state_d = S_RESP;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts_i.have_best) begin
          cmd_o.rec_alloc = 1'b1;
          state_d         = S_MARK;
        end else begin
          code_d  = ST_NOFIT;
          state_d = S_RESP;
        end
      end
      S_MARK: begin
        cmd_o.mark = 1'b1;
        if (sts_i.mark_last) begin
          code_d  = ST_OK;
          grant_d = 1'b1;
          state_d = S_RESP;
        end
      end
      S_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (sts_i.walk_hit) begin
          state_d = S_UNMARK;
        end else if (sts_i.walk_end) begin
          code_d  = ST_NOTFOUND;
          state_d = S_RESP;
        end
      end
      S_UNMARK: begin
        cmd_o.unmark = 1'b1;
        if (sts_i.unmark_last) begin
          code_d  = ST_OK;
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (!sts_i.rsp_busy) begin
          cmd_o.rsp_load   = 1'b1;
          cmd_o.rsp_grant  = grant_q;
          cmd_o.rsp_status = code_q;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Best-fit page allocator testbench
// Sends allocate and free requests, computes each expected grant with a
// behavioral model of the page map and record table, and compares every
// response beat against it in order.
// ----------------------------------------------------------------------------
module testbench;
  import bfpa_pkg::*;

  // The block is built with its default geometry, and the model mirrors it.
  localparam int MAP_PAGES = 1024;
  localparam int SLOTS = 64;

  // An allocate scans the whole map once, tests up to every slot and marks up
  // to a full heap of pages. The tail wait after the last beat covers one
  // such request.
  localparam int DRAIN_TAIL = 2 * MAP_PAGES + SLOTS + 64;

  // The slowest correct run is roughly 540 requests of the slowest kind, plus
  // the clearing sweep after reset and the long response hold. The limit
  // allows several times that.
  localparam longint CYCLE_LIMIT = 64'd5_000_000;

  // The response side stops taking beats for this long once, while requests
  // keep coming, so the output register fills and the request side stalls.
  localparam int HOLD_AT_BEAT = 150;
  localparam int HOLD_CYCLES = 6000;

  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 75;
  localparam int PLAN_ROWS = 24;

  typedef struct {
    kind_e              kind;
    logic [BYTES_W-1:0] bytes;
    logic [ADDR_W-1:0]  faddr;
    bit                 known;       // grant below is fixed, not computed
    logic [ADDR_W-1:0]  want_addr;
    status_e            want_status;
  } request_t;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    status_e           status;
  } grant_t;

  // The clock starts low so that the first falling edge comes one period in.
  logic clk_i = 1'b0;
  logic rst_ni;

  bfpa_req_if req_ch ();
  bfpa_rsp_if rsp_ch ();
  bfpa_cfg_if cfg_ch ();

  best_fit_page_allocator #(
    .HEAP_PAGES  (MAP_PAGES),
    .RECORD_SLOTS(SLOTS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_ch),
    .rsp_o (rsp_ch),
    .cfg_i (cfg_ch)
  );

  // Model state: page occupancy, the record table and the heap base register.
  bit                    map_busy [MAP_PAGES];
  bit                    slot_live [SLOTS];
  int                    slot_first [SLOTS];
  int                    slot_pages [SLOTS];
  logic [ADDR_W-1:0]     window_base;

  grant_t pending_grants[$];
  int     mismatches;
  int     beats;
  longint cycle_count;
  bit     rsp_calm;

  // The clock runs with a 4 ns period.
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // The watchdog ends a run that hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [ADDR_W-1:0] page_address(int page);
    logic [ADDR_W-1:0] offset;
    offset = ADDR_W'(page) << PAGE_SHIFT;
    return window_base + offset;
  endfunction

  // Computes the grant for one accepted request and updates the model state.
  // An allocate tests in order: zero size, table full, then no fitting run.
  // Best fit takes the shortest maximal free run that holds the request, and
  // the lowest such run on a tie.
  function automatic grant_t predict_grant(request_t rq);
    grant_t g;
    int     s;
    int     p;
    int     need;
    int     slot;
    int     run;
    int     run_first;
    int     best_len;
    int     best_first;
    bit     found;
    bit     free_here;
    g.addr = '0;
    g.status = ST_NOTFOUND;
    if (rq.kind == KIND_FREE) begin
      for (s = 0; s < SLOTS; s++) begin
        if (slot_live[s] && page_address(slot_first[s]) == rq.faddr) begin
          for (p = 0; p < slot_pages[s]; p++) begin
            map_busy[slot_first[s] + p] = 1'b0;
          end
          slot_live[s] = 1'b0;
          g.status = ST_OK;
          break;
        end
      end
      return g;
    end
    if (rq.bytes == '0) begin
      g.status = ST_ZERO;
      return g;
    end
    slot = -1;
    for (s = 0; s < SLOTS; s++) begin
      if (!slot_live[s]) begin
        slot = s;
        break;
      end
    end
    if (slot < 0) begin
      g.status = ST_FULL;
      return g;
    end
    need = (int'(rq.bytes) + int'(PAGE_BYTES) - 1) >> PAGE_SHIFT;
    found = 1'b0;
    best_len = 0;
    best_first = 0;
    run = 0;
    run_first = 0;
    // The extra step past the last page closes a run that reaches the end.
    for (p = 0; p <= MAP_PAGES; p++) begin
      free_here = (p < MAP_PAGES) && !map_busy[p];
      if (free_here) begin
        if (run == 0) run_first = p;
        run++;
      end else begin
        if (run >= need && (!found || run < best_len)) begin
          found = 1'b1;
          best_len = run;
          best_first = run_first;
        end
        run = 0;
      end
    end
    if (!found) begin
      g.status = ST_NOFIT;
      return g;
    end
    for (p = 0; p < need; p++) begin
      map_busy[best_first + p] = 1'b1;
    end
    slot_live[slot] = 1'b1;
    slot_first[slot] = best_first;
    slot_pages[slot] = need;
    g.addr = page_address(best_first);
    g.status = ST_OK;
    return g;
  endfunction

  // Draws one random request. Most frees name a live block so that the map
  // keeps changing; the rest are stray addresses: random words, addresses
  // inside a live block, and pages of the window at its reset base.
  function automatic request_t random_request(int alloc_pct);
    request_t rq;
    int       pick;
    int       pages;
    int       live[$];
    int       s;
    rq.known = 1'b0;
    rq.want_addr = '0;
    rq.want_status = ST_OK;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < alloc_pct) begin
      rq.kind = KIND_ALLOC;
      rq.faddr = $urandom;
      if (pick < 4) begin
        rq.bytes = '0;
      end else if (pick < 96) begin
        if (pick < 70) pages = $urandom_range(1, 8);
        else if (pick < 88) pages = $urandom_range(9, 128);
        else pages = $urandom_range(129, MAP_PAGES);
        rq.bytes = BYTES_W'((pages - 1) * int'(PAGE_BYTES)
                            + $urandom_range(1, PAGE_BYTES));
      end else begin
        // Larger than the whole heap, up to the widest field value.
        rq.bytes = BYTES_W'($urandom_range(MAP_PAGES * PAGE_BYTES + 1,
                                           (1 << BYTES_W) - 1));
      end
    end else begin
      rq.kind = KIND_FREE;
      rq.bytes = BYTES_W'($urandom_range(0, (1 << BYTES_W) - 1));
      for (s = 0; s < SLOTS; s++) begin
        if (slot_live[s]) live.push_back(s);
      end
      if (live.size() > 0 && pick < 80) begin
        s = live[$urandom_range(0, live.size() - 1)];
        rq.faddr = page_address(slot_first[s]);
      end else if (live.size() > 0 && pick < 88) begin
        s = live[$urandom_range(0, live.size() - 1)];
        rq.faddr = page_address(slot_first[s]) + $urandom_range(1, PAGE_BYTES - 1);
      end else if (pick < 94) begin
        rq.faddr = HEAP_BASE_RST
                   + (ADDR_W'($urandom_range(0, MAP_PAGES - 1)) << PAGE_SHIFT);
      end else begin
        rq.faddr = $urandom;
      end
    end
    return rq;
  endfunction

  // Presents one request and waits for its beat. The grant is computed at
  // acceptance, when the model holds exactly the state the block sees.
  task automatic send_request(request_t rq, bit calm);
    int     gap;
    grant_t g;
    gap = calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_ch.kind = rq.kind;
    req_ch.request_bytes = rq.bytes;
    req_ch.free_address = rq.faddr;
    req_ch.valid = 1'b1;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    g = predict_grant(rq);
    if (rq.known) begin
      g.addr = rq.want_addr;
      g.status = rq.want_status;
    end
    pending_grants.push_back(g);
    @(negedge clk_i);
  endtask

  // Stops offering requests and waits until every expected grant has come.
  // Every request gives exactly one grant, so the block is idle afterwards.
  task automatic settle();
    req_ch.valid = 1'b0;
    while (pending_grants.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_heap_base(logic [ADDR_W-1:0] value);
    settle();
    cfg_ch.heap_base = value;
    cfg_ch.valid = 1'b1;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    window_base = value;
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
  endtask

  // Response side: takes beats with random stalls and checks each one against
  // the oldest expected grant, field by field.
  initial begin : response_side
    int                gap;
    grant_t            want;
    logic [ADDR_W-1:0] got_addr;
    logic [2:0]        got_status;
    rsp_ch.ready = 1'b0;
    rsp_calm = 1'b0;
    @(negedge clk_i);
    forever begin
      if (beats == HOLD_AT_BEAT) begin
        rsp_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      gap = rsp_calm ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        rsp_ch.ready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      rsp_ch.ready = 1'b1;
      @(posedge clk_i);
      while (!rsp_ch.valid) @(posedge clk_i);
      got_addr = rsp_ch.granted_address;
      got_status = rsp_ch.status;
      if (pending_grants.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: response beat with nothing expected: address %h status %0d",
                   $realtime, got_addr, got_status);
        end
      end else begin
        want = pending_grants.pop_front();
        if (got_addr !== want.addr) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: granted_address expected %h got %h (beat %0d)",
                     $realtime, want.addr, got_addr, beats);
          end
        end
        if (got_status !== want.status) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: status expected %s got %0d (beat %0d)",
                     $realtime, want.status.name(), got_status, beats);
          end
        end
      end
      beats++;
      // Every forty beats the response side may switch to a stretch of
      // back-to-back acceptance.
      if (beats % 40 == 0) rsp_calm = ($urandom_range(0, 3) == 0);
      @(negedge clk_i);
    end
  end

  // Request side and run control.
  initial begin : request_side
    request_t          plan [PLAN_ROWS];
    request_t          rq;
    logic [ADDR_W-1:0] bases [PHASES];
    int                alloc_bias [PHASES];
    int                i;
    int                ph;

    req_ch.valid = 1'b0;
    req_ch.kind = KIND_ALLOC;
    req_ch.request_bytes = '0;
    req_ch.free_address = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.heap_base = '0;
    mismatches = 0;
    beats = 0;
    cycle_count = 0;

    window_base = HEAP_BASE_RST;
    map_busy = '{default: 1'b0};
    slot_live = '{default: 1'b0};
    slot_first = '{default: 0};
    slot_pages = '{default: 0};

    rst_ni = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed requests at the reset base. Rows with a fixed grant can be read
    // straight off the map state; the best-fit picks are left to the model.
    // Ignored fields carry their extreme values on some rows.
    plan = '{
      // Zero size, and a free with nothing allocated.
      '{KIND_ALLOC, 23'h00_0000, 32'hFFFF_FFFF, 1'b1, 32'h0, ST_ZERO},
      '{KIND_FREE,  23'h7F_FFFF, HEAP_BASE_RST, 1'b1, 32'h0, ST_NOTFOUND},
      // One byte, exactly one page, one page plus a byte.
      '{KIND_ALLOC, 23'h00_0001, 32'h0, 1'b1, HEAP_BASE_RST, ST_OK},
      '{KIND_ALLOC, 23'h00_1000, 32'h0, 1'b1, HEAP_BASE_RST + 32'h1000, ST_OK},
      '{KIND_ALLOC, 23'h00_1001, 32'h0, 1'b1, HEAP_BASE_RST + 32'h2000, ST_OK},
      // Too large: widest field value and the whole heap.
      '{KIND_ALLOC, 23'h7F_FFFF, 32'h0, 1'b1, 32'h0, ST_NOFIT},
      '{KIND_ALLOC, 23'h40_0000, 32'h0, 1'b1, 32'h0, ST_NOFIT},
      // The rest of the heap exactly, then nothing is left.
      '{KIND_ALLOC, 23'h3F_C000, 32'h0, 1'b1, HEAP_BASE_RST + 32'h4000, ST_OK},
      '{KIND_ALLOC, 23'h00_0001, 32'h0, 1'b1, 32'h0, ST_NOFIT},
      // Punch holes; an address inside a block is not a start.
      '{KIND_FREE,  23'h0, HEAP_BASE_RST + 32'h1000, 1'b1, 32'h0, ST_OK},
      '{KIND_FREE,  23'h0, HEAP_BASE_RST + 32'h4000, 1'b1, 32'h0, ST_OK},
      '{KIND_FREE,  23'h0, HEAP_BASE_RST + 32'h3000, 1'b1, 32'h0, ST_NOTFOUND},
      // Best fit: the one-page hole, then the big run.
      '{KIND_ALLOC, 23'h00_1000, 32'h0, 1'b0, 32'h0, ST_OK},
      '{KIND_ALLOC, 23'h00_2000, 32'h0, 1'b0, 32'h0, ST_OK},
      '{KIND_FREE,  23'h0, HEAP_BASE_RST, 1'b1, 32'h0, ST_OK},
      '{KIND_FREE,  23'h0, HEAP_BASE_RST + 32'h2000, 1'b1, 32'h0, ST_OK},
      // Best fit: the two-page hole beats the long tail, one page takes the
      // single-page hole at the bottom.
      '{KIND_ALLOC, 23'd5000, 32'h0, 1'b0, 32'h0, ST_OK},
      '{KIND_ALLOC, 23'd100, 32'h0, 1'b0, 32'h0, ST_OK},
      '{KIND_FREE,  23'h0, 32'h0000_0000, 1'b1, 32'h0, ST_NOTFOUND},
      '{KIND_FREE,  23'h0, 32'hFFFF_FFFF, 1'b1, 32'h0, ST_NOTFOUND},
      // Release everything that is left.
      '{KIND_FREE,  23'h0, HEAP_BASE_RST, 1'b1, 32'h0, ST_OK},
      '{KIND_FREE,  23'h0, HEAP_BASE_RST + 32'h1000, 1'b1, 32'h0, ST_OK},
      '{KIND_FREE,  23'h0, HEAP_BASE_RST + 32'h2000, 1'b1, 32'h0, ST_OK},
      '{KIND_FREE,  23'h0, HEAP_BASE_RST + 32'h4000, 1'b1, 32'h0, ST_OK}
    };
    for (i = 0; i < PLAN_ROWS; i++) begin
      send_request(plan[i], 1'b0);
    end

    // Fill every record slot with one-page blocks, back to back. Once the
    // table is full, a zero size still reports zero size, and a request too
    // large for the heap reports table full, since that check comes first.
    rq.kind = KIND_ALLOC;
    rq.known = 1'b0;
    rq.want_addr = '0;
    rq.want_status = ST_OK;
    for (i = 0; i < SLOTS; i++) begin
      rq.bytes = BYTES_W'($urandom_range(1, PAGE_BYTES));
      rq.faddr = $urandom;
      send_request(rq, 1'b1);
    end
    rq.bytes = 23'h00_0001;
    send_request(rq, 1'b1);
    rq.bytes = 23'h00_0000;
    send_request(rq, 1'b1);
    rq.bytes = 23'h7F_FFFF;
    send_request(rq, 1'b1);

    // Random phases, each under its own heap base. Live blocks survive a base
    // change and are freed at their address in the new window. The allocate
    // share swings from draining the full table to refilling it.
    bases = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, 32'hFFFF_F000,
              $urandom & 32'hFFFF_F000, HEAP_BASE_RST};
    alloc_bias = '{35, 65, 55, 90, 60, 25};
    for (ph = 0; ph < PHASES; ph++) begin
      write_heap_base(bases[ph]);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        send_request(random_request(alloc_bias[ph]), ph % 2 == 1);
      end
    end

    settle();
    repeat (DRAIN_TAIL) @(negedge clk_i);
    if (mismatches == 0 && pending_grants.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
